/* rtl/core/skeleton_joint_matrix_palette_defines.svh */
// Assertion macros shared by the joint matrix palette RTL.
`ifndef SKELETON_JOINT_MATRIX_PALETTE_DEFINES_SVH
`define SKELETON_JOINT_MATRIX_PALETTE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SJMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SJMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sjmp_pkg.sv */
// Shared types, opcodes and tables of the joint matrix palette.
package sjmp_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned WORDS_PER_JOINT = 12;

  localparam logic [1:0] REQ_TRANS = 2'd0;
  localparam logic [1:0] REQ_ROT   = 2'd1;
  localparam logic [1:0] REQ_SCALE = 2'd2;
  localparam logic [1:0] REQ_COL   = 2'd3;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_QP   = 3'd1;  // quaternion cross products
  localparam logic [2:0] OP_LOC  = 3'd2;  // rotation times scale
  localparam logic [2:0] OP_WLD  = 3'd3;  // parent times local
  localparam logic [2:0] OP_COL  = 3'd4;  // world times bind column

  localparam logic [3:0] QP_LAST   = 4'd8;
  localparam logic [3:0] WORD_LAST = 4'd11;
  localparam logic [3:0] WORD_D0   = 4'd0;
  localparam logic [3:0] WORD_D1   = 4'd5;
  localparam logic [3:0] WORD_D2   = 4'd10;

  typedef struct packed {
    logic [2:0] op;
    logic       cap;
    logic       rot_ld;
    logic       rd;
    logic       use_parent;
    logic       clr;
    logic       out_ld;
    logic       first;
    logic       last;
    logic [1:0] r;
    logic [1:0] c;
    logic [1:0] k;
    logic [3:0] n;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       joint_ok;
    logic       out_busy;
  } stat_t;

  // operand pairs xx yy zz xy xz yz wx wy wz (0..3 = x y z w)
  function automatic logic [1:0] qp_a(input logic [3:0] n);
    logic [1:0] v;
    case (n)
      4'd0: v = 2'd0;
      4'd1: v = 2'd1;
      4'd2: v = 2'd2;
      4'd3: v = 2'd0;
      4'd4: v = 2'd0;
      4'd5: v = 2'd1;
      4'd6: v = 2'd3;
      4'd7: v = 2'd3;
      4'd8: v = 2'd3;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] qp_b(input logic [3:0] n);
    logic [1:0] v;
    case (n)
      4'd0: v = 2'd0;
      4'd1: v = 2'd1;
      4'd2: v = 2'd2;
      4'd3: v = 2'd1;
      4'd4: v = 2'd2;
      4'd5: v = 2'd2;
      4'd6: v = 2'd0;
      4'd7: v = 2'd1;
      4'd8: v = 2'd2;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

  function automatic logic is_diag(input logic [3:0] n);
    return (n == WORD_D0) || (n == WORD_D1) || (n == WORD_D2);
  endfunction

endpackage

/* rtl/core/skeleton_joint_matrix_palette.sv */
// Joint matrix palette: local and world transforms per joint, skinning columns out.
// Translation and rotation beats are only captured. A scale beat holds in_tready low for
// quaternion, local and world products on one shared 32x32 multiplier and the parent reads.
// A bind column beat reads the world words, runs its products and drains, then raises
// out_tvalid; it holds while a result still waits. One beat is in work at a time.
// After reset a clear pass writes identity into every joint's words with in_tready low.
module skeleton_joint_matrix_palette import sjmp_pkg::*; #(
  parameter int unsigned MAX_JOINTS = 256,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // joint_index[7:0], parent_index[15:8], column_index[17:16], v0..v3 from bit 18
  input  logic [151:0] in_tdata,
  // req_type
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_joint[7:0], out_column[9:8], e0..e3 from bit 10
  output logic [143:0] out_tdata,
  // saturated
  output logic         out_tuser
);

  localparam int unsigned JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  cmd_t          cmd;
  stat_t         st;
  logic [JW-1:0] clr_joint;

  sjmp_ctrl #(
    .MAX_JOINTS (MAX_JOINTS),
    .JW         (JW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd),
    .clr_joint (clr_joint)
  );

  sjmp_dp #(
    .MAX_JOINTS (MAX_JOINTS),
    .FRAC_BITS  (FRAC_BITS),
    .JW         (JW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .clr_joint  (clr_joint),
    .st         (st)
  );

endmodule

/* rtl/core/sjmp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sjmp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/sjmp_ctrl.sv */
// Sequencer: clear pass, joint build and column product schedules.
`include "skeleton_joint_matrix_palette_defines.svh"
module sjmp_ctrl import sjmp_pkg::*; #(
  parameter int unsigned MAX_JOINTS = 256,
  parameter int unsigned JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  stat_t         st,
  output cmd_t          cmd,
  output logic [JW-1:0] clr_joint
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_QP   = 4'd2;
  localparam logic [3:0] S_QW   = 4'd3;
  localparam logic [3:0] S_ROT  = 4'd4;
  localparam logic [3:0] S_LOC  = 4'd5;
  localparam logic [3:0] S_LDP  = 4'd6;
  localparam logic [3:0] S_WLD  = 4'd7;
  localparam logic [3:0] S_WDR  = 4'd8;
  localparam logic [3:0] S_LDC  = 4'd9;
  localparam logic [3:0] S_COL  = 4'd10;
  localparam logic [3:0] S_CDR  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  localparam logic [JW-1:0] CLR_LAST = JW'(MAX_JOINTS - 1);

  logic [3:0]    state_r, state_nxt;
  logic [3:0]    n_r, n_nxt;
  logic [1:0]    r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  logic [JW-1:0] clr_j_r, clr_j_nxt;
  logic          accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign clr_joint = clr_j_r;

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    clr_j_nxt = clr_j_r;
    cmd       = '0;
    cmd.cap   = accept;
    cmd.r     = r_r;
    cmd.c     = c_r;
    cmd.k     = k_r;
    cmd.n     = n_r;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (n_r == WORD_LAST) begin
          n_nxt = '0;
          if (clr_j_r == CLR_LAST) begin
            state_nxt = S_IDLE;
          end else begin
            clr_j_nxt = clr_j_r + 1'b1;
          end
        end else begin
          n_nxt = n_r + 1'b1;
        end
      end
      S_IDLE: begin
        n_nxt = '0;
        r_nxt = '0;
        c_nxt = '0;
        k_nxt = '0;
        if (accept && st.joint_ok && (st.req_type == REQ_SCALE)) begin
          state_nxt = S_QP;
        end else if (accept && st.joint_ok && (st.req_type == REQ_COL)) begin
          state_nxt = S_LDC;
        end
      end
      S_QP: begin
        cmd.op = OP_QP;
        if (n_r == QP_LAST) begin
          n_nxt     = '0;
          state_nxt = S_QW;
        end else begin
          n_nxt = n_r + 1'b1;
        end
      end
      S_QW: state_nxt = S_ROT;
      S_ROT: begin
        cmd.rot_ld = 1'b1;
        state_nxt  = S_LOC;
      end
      S_LOC: begin
        cmd.op = OP_LOC;
        if (c_r == 2'd2) begin
          c_nxt = '0;
          if (r_r == 2'd2) begin
            r_nxt     = '0;
            state_nxt = S_LDP;
          end else begin
            r_nxt = r_r + 1'b1;
          end
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      S_LDP: begin
        cmd.rd         = 1'b1;
        cmd.use_parent = 1'b1;
        if (n_r == WORD_LAST) begin
          n_nxt     = '0;
          state_nxt = S_WLD;
        end else begin
          n_nxt = n_r + 1'b1;
        end
      end
      S_WLD: begin
        cmd.op    = OP_WLD;
        cmd.first = (k_r == 2'd0);
        cmd.last  = (k_r == 2'd2);
        if (k_r == 2'd2) begin
          k_nxt = '0;
          if (c_r == 2'd3) begin
            c_nxt = '0;
            if (r_r == 2'd2) begin
              r_nxt     = '0;
              state_nxt = S_WDR;
            end else begin
              r_nxt = r_r + 1'b1;
            end
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_WDR: state_nxt = S_IDLE;
      S_LDC: begin
        cmd.rd = 1'b1;
        if (n_r == WORD_LAST) begin
          n_nxt     = '0;
          state_nxt = S_COL;
        end else begin
          n_nxt = n_r + 1'b1;
        end
      end
      S_COL: begin
        cmd.op    = OP_COL;
        cmd.first = (k_r == 2'd0);
        cmd.last  = (k_r == 2'd3);
        if (k_r == 2'd3) begin
          k_nxt = '0;
          if (r_r == 2'd2) begin
            r_nxt     = '0;
            state_nxt = S_CDR;
          end else begin
            r_nxt = r_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_CDR: state_nxt = S_OUT;
      S_OUT: begin
        // hold the finished column until the output register frees up
        if (!st.out_busy) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      n_r     <= '0;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
      clr_j_r <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
      clr_j_r <= clr_j_nxt;
    end
  end

  `SJMP_ASSERT_NOW(a_out_ld_free, cmd.out_ld, !st.out_busy, "result loaded over a waiting beat")
  `SJMP_ASSERT_NOW(a_wld_k_range, state_r == S_WLD, k_r != 2'd3, "world product k out of range")
  `SJMP_ASSERT_NEXT(a_qp_to_wait, (state_r == S_QP) && (n_r == QP_LAST), state_r == S_QW,
                    "quaternion products did not end")
  `SJMP_ASSERT_NOW(a_clr_no_take, state_r == S_CLR, !in_tready, "input taken during clear")

endmodule

/* rtl/core/sjmp_dp.sv */
// Datapath: held inputs, shared multiplier, accumulator, world store, output register.
module sjmp_dp import sjmp_pkg::*; #(
  parameter int unsigned MAX_JOINTS = 256,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [151:0]   in_tdata,
  input  logic [1:0]     in_tuser,
  output logic [143:0]   out_tdata,
  output logic           out_tuser,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  cmd_t           cmd,
  input  logic [JW-1:0]  clr_joint,
  output stat_t          st
);

  localparam int unsigned DEPTH = MAX_JOINTS * WORDS_PER_JOINT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = 64 - FRAC_BITS;   // rounded product
  localparam int unsigned XW    = RW + 3;           // sums of products
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [XW-1:0] ONE_X = XW'(ONE);
  localparam logic signed [XW-1:0] MAX_X = XW'(32'sh7FFFFFFF);
  localparam logic signed [XW-1:0] MIN_X = XW'($signed(32'h80000000));

  function automatic logic signed [31:0] clamp(input logic signed [XW-1:0] v);
    logic signed [31:0] o;
    if (v > MAX_X) begin
      o = 32'sh7FFFFFFF;
    end else if (v < MIN_X) begin
      o = $signed(32'h80000000);
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

  function automatic logic is_clamped(input logic signed [XW-1:0] v);
    return (v > MAX_X) || (v < MIN_X);
  endfunction

  // input fields
  logic [7:0]         in_joint, in_parent;
  logic [1:0]         in_col;
  logic signed [31:0] in_v [4];
  assign in_joint  = in_tdata[7:0];
  assign in_parent = in_tdata[15:8];
  assign in_col    = in_tdata[17:16];
  assign in_v[0]   = $signed(in_tdata[49:18]);
  assign in_v[1]   = $signed(in_tdata[81:50]);
  assign in_v[2]   = $signed(in_tdata[113:82]);
  assign in_v[3]   = $signed(in_tdata[145:114]);

  logic signed [31:0] t_r [3];
  logic signed [31:0] q_r [4];
  logic [7:0]         par_r;
  logic signed [31:0] s_r [3];
  logic signed [31:0] vin_r [4];
  logic [7:0]         jn_r;
  logic [1:0]         col_r;

  logic signed [RW-1:0] qp_r [9];
  logic signed [31:0]   rot_r [9];
  logic signed [31:0]   loc_r [9];
  logic signed [31:0]   mat_r [12];
  logic signed [XW-1:0] acc_r;
  logic signed [31:0]   e_r [3];
  logic [2:0]           esat_r;

  cmd_t                 cmd_d_r;
  logic signed [63:0]   p_r;
  logic                 out_valid_r;
  logic [143:0]         out_data_r;
  logic                 out_sat_r;

  assign st.req_type = in_tuser;
  assign st.joint_ok = 32'(in_joint) < MAX_JOINTS;
  assign st.out_busy = out_valid_r && !out_tready;

  // multiplier operands
  logic signed [31:0] op_a, op_b;
  logic [3:0]         idx_rc3, idx_kc3, idx_rk;
  assign idx_rc3 = {2'b0, cmd.r} * 4'd3 + {2'b0, cmd.c};
  assign idx_kc3 = {2'b0, cmd.k} * 4'd3 + {2'b0, cmd.c};
  assign idx_rk  = {cmd.r, cmd.k};

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.op)
      OP_QP: begin
        op_a = q_r[qp_a(cmd.n)];
        op_b = q_r[qp_b(cmd.n)];
      end
      OP_LOC: begin
        op_a = rot_r[idx_rc3];
        op_b = s_r[cmd.c];
      end
      OP_WLD: begin
        op_a = mat_r[idx_rk];
        op_b = (cmd.c == 2'd3) ? t_r[cmd.k] : loc_r[idx_kc3];
      end
      OP_COL: begin
        op_a = mat_r[idx_rk];
        op_b = vin_r[cmd.k];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // rounding of the registered product
  logic signed [63:0]   p_half;
  logic signed [RW-1:0] rnd_v;
  logic signed [XW-1:0] rnd_x, bias, sum;
  logic [3:0]           d_rc3, d_rk, d_rc4;
  assign p_half = p_r + HALF;
  assign rnd_v  = RW'(p_half >>> FRAC_BITS);
  assign rnd_x  = XW'(rnd_v);
  assign d_rc3  = {2'b0, cmd_d_r.r} * 4'd3 + {2'b0, cmd_d_r.c};
  assign d_rk   = {cmd_d_r.r, 2'd3};
  assign d_rc4  = {cmd_d_r.r, cmd_d_r.c};
  assign bias   = ((cmd_d_r.op == OP_WLD) && (cmd_d_r.c == 2'd3)) ? XW'(mat_r[d_rk]) : '0;
  assign sum    = (cmd_d_r.first ? bias : acc_r) + rnd_x;

  // world store
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, w_base, r_base, c_base;
  logic [31:0]   ram_wdata, ram_rdata;
  logic          par_big, ident_d;

  assign w_base  = (AW'(jn_r) << 3) + (AW'(jn_r) << 2);
  assign c_base  = (AW'(clr_joint) << 3) + (AW'(clr_joint) << 2);
  assign r_base  = cmd.use_parent ? (AW'(par_r) << 3) + (AW'(par_r) << 2) : w_base;
  assign par_big = 32'(par_r) >= MAX_JOINTS;
  assign ident_d = cmd_d_r.use_parent && ((jn_r == 8'd0) || par_big);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = c_base + AW'(cmd.n);
    ram_wdata = is_diag(cmd.n) ? ONE : '0;
    if (cmd.clr) begin
      ram_we = 1'b1;
    end else if ((cmd_d_r.op == OP_WLD) && cmd_d_r.last) begin
      ram_we    = 1'b1;
      ram_waddr = w_base + AW'(d_rc4);
      ram_wdata = clamp(sum);
    end
  end

  assign ram_raddr = r_base + AW'(cmd.n);

  sjmp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_world (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control and held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_d_r     <= '0;
      out_valid_r <= 1'b0;
      par_r       <= '0;
      for (int i = 0; i < 3; i++) begin
        t_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        q_r[i] <= '0;
      end
    end else begin
      cmd_d_r <= cmd;
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.cap && (in_tuser == REQ_TRANS)) begin
        par_r <= in_parent;
        for (int i = 0; i < 3; i++) begin
          t_r[i] <= in_v[i];
        end
      end
      if (cmd.cap && (in_tuser == REQ_ROT)) begin
        for (int i = 0; i < 4; i++) begin
          q_r[i] <= in_v[i];
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    p_r <= 64'(op_a) * 64'(op_b);
    if (cmd.cap) begin
      jn_r  <= in_joint;
      col_r <= in_col;
      if (in_tuser == REQ_SCALE) begin
        for (int i = 0; i < 3; i++) begin
          s_r[i] <= in_v[i];
        end
      end
      if (in_tuser == REQ_COL) begin
        for (int i = 0; i < 4; i++) begin
          vin_r[i] <= in_v[i];
        end
      end
    end
    if (cmd.rot_ld) begin
      rot_r[0] <= clamp(ONE_X - ((XW'(qp_r[1]) + XW'(qp_r[2])) <<< 1));
      rot_r[1] <= clamp((XW'(qp_r[3]) - XW'(qp_r[8])) <<< 1);
      rot_r[2] <= clamp((XW'(qp_r[4]) + XW'(qp_r[7])) <<< 1);
      rot_r[3] <= clamp((XW'(qp_r[3]) + XW'(qp_r[8])) <<< 1);
      rot_r[4] <= clamp(ONE_X - ((XW'(qp_r[0]) + XW'(qp_r[2])) <<< 1));
      rot_r[5] <= clamp((XW'(qp_r[5]) - XW'(qp_r[6])) <<< 1);
      rot_r[6] <= clamp((XW'(qp_r[4]) - XW'(qp_r[7])) <<< 1);
      rot_r[7] <= clamp((XW'(qp_r[5]) + XW'(qp_r[6])) <<< 1);
      rot_r[8] <= clamp(ONE_X - ((XW'(qp_r[0]) + XW'(qp_r[1])) <<< 1));
    end
    if (cmd_d_r.rd) begin
      mat_r[cmd_d_r.n] <= ident_d ? (is_diag(cmd_d_r.n) ? ONE : '0) : $signed(ram_rdata);
    end
    case (cmd_d_r.op)
      OP_QP:  qp_r[cmd_d_r.n] <= rnd_v;
      OP_LOC: loc_r[d_rc3] <= clamp(rnd_x);
      OP_WLD: acc_r <= sum;
      OP_COL: begin
        acc_r <= sum;
        if (cmd_d_r.last) begin
          e_r[cmd_d_r.r]    <= clamp(sum);
          esat_r[cmd_d_r.r] <= is_clamped(sum);
        end
      end
      default: ;
    endcase
    if (cmd.out_ld) begin
      out_data_r <= {6'b0, vin_r[3], e_r[2], e_r[1], e_r[0], col_r, jn_r};
      out_sat_r  <= |esat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

/* tb/skeleton_joint_matrix_palette_chk.sv */
// Checker: predicts skinning columns of the joint matrix palette and compares output beats.
module skeleton_joint_matrix_palette_chk import sjmp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [151:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [143:0] out_tdata,
  input  logic         out_tuser,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NJ = 256;
  localparam int FB = 16;
  localparam longint ONE = 64'sd1 <<< FB;

  typedef struct packed {
    logic [7:0]  joint;
    logic [1:0]  column;
    logic [31:0] e0, e1, e2, e3;
    logic        sat;
  } column_t;

  logic signed [31:0] world [NJ*12];
  logic signed [31:0] trans_q [3];
  logic signed [31:0] quat_q [4];
  logic [7:0]         parent_q;
  column_t            col_fifo [$];

  function automatic longint fx_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< (FB-1))) >>> FB;
  endfunction

  function automatic longint clip(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin flag = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin flag = 1; return -64'sd2147483648; end
    return v;
  endfunction

  task automatic compose_world(int j, longint sx, longint sy, longint sz);
    longint x, y, z, w, xx, yy, zz, xy, xz, yz, wx, wy, wz, acc;
    longint rot [3][3];
    longint loc [3][4];
    longint par [3][4];
    longint sc [3];
    bit d;
    x = quat_q[0]; y = quat_q[1]; z = quat_q[2]; w = quat_q[3];
    xx = fx_mul(x, x); yy = fx_mul(y, y); zz = fx_mul(z, z);
    xy = fx_mul(x, y); xz = fx_mul(x, z); yz = fx_mul(y, z);
    wx = fx_mul(w, x); wy = fx_mul(w, y); wz = fx_mul(w, z);
    rot[0][0] = ONE - 2*(yy+zz); rot[0][1] = 2*(xy-wz); rot[0][2] = 2*(xz+wy);
    rot[1][0] = 2*(xy+wz); rot[1][1] = ONE - 2*(xx+zz); rot[1][2] = 2*(yz-wx);
    rot[2][0] = 2*(xz-wy); rot[2][1] = 2*(yz+wx); rot[2][2] = ONE - 2*(xx+yy);
    sc[0] = sx; sc[1] = sy; sc[2] = sz;
    d = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) loc[r][c] = clip(fx_mul(clip(rot[r][c], d), sc[c]), d);
      loc[r][3] = trans_q[r];
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        par[r][c] = (j == 0) ? ((r == c) ? ONE : 0) : world[parent_q*12 + r*4 + c];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) begin
        acc = (c == 3) ? par[r][3] : 0;
        for (int k = 0; k < 3; k++) acc += fx_mul(par[r][k], loc[k][c]);
        world[j*12 + r*4 + c] = 32'(clip(acc, d));
      end
  endtask

  always @(posedge clk) begin
    longint v [4];
    longint acc;
    longint e [3];
    bit sat;
    column_t exp_c, got;
    int j;
    if (!rst_n) begin
      for (int i = 0; i < NJ*12; i++) world[i] = ((i % 12) inside {0, 5, 10}) ? 32'(ONE) : 0;
      trans_q = '{default: 0};
      quat_q = '{default: 0};
      parent_q = 0;
      col_fifo.delete();
      fail_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.joint = out_tdata[7:0]; got.column = out_tdata[9:8];
        got.e0 = out_tdata[41:10]; got.e1 = out_tdata[73:42];
        got.e2 = out_tdata[105:74]; got.e3 = out_tdata[137:106];
        got.sat = out_tuser;
        if (col_fifo.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_c = col_fifo.pop_front();
          if (got !== exp_c) begin
            $display("%0t: column mismatch expected j=%0d c=%0d %h %h %h %h s=%0b",
                     $time, exp_c.joint, exp_c.column, exp_c.e0, exp_c.e1, exp_c.e2,
                     exp_c.e3, exp_c.sat);
            $display("%0t:                 actual j=%0d c=%0d %h %h %h %h s=%0b",
                     $time, got.joint, got.column, got.e0, got.e1, got.e2, got.e3, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        for (int i = 0; i < 4; i++) v[i] = longint'($signed(in_tdata[18+32*i +: 32]));
        j = int'(in_tdata[7:0]);
        case (in_tuser)
          REQ_TRANS: begin
            for (int i = 0; i < 3; i++) trans_q[i] = 32'(v[i]);
            parent_q = in_tdata[15:8];
          end
          REQ_ROT: for (int i = 0; i < 4; i++) quat_q[i] = 32'(v[i]);
          REQ_SCALE: compose_world(j, v[0], v[1], v[2]);
          default: begin
            sat = 0;
            for (int r = 0; r < 3; r++) begin
              acc = 0;
              for (int k = 0; k < 4; k++) acc += fx_mul(world[j*12 + r*4 + k], v[k]);
              e[r] = clip(acc, sat);
            end
            exp_c.joint = 8'(j); exp_c.column = in_tdata[17:16];
            exp_c.e0 = 32'(e[0]); exp_c.e1 = 32'(e[1]); exp_c.e2 = 32'(e[2]);
            exp_c.e3 = 32'(v[3]); exp_c.sat = sat;
            col_fifo.push_back(exp_c);
          end
        endcase
      end
    end
  end

  assign pending = col_fifo.size();
endmodule

/* tb/tb_skeleton_joint_matrix_palette.sv */
// Testbench top: drives joint beats with random idling and reports the verdict.
module tb_skeleton_joint_matrix_palette import sjmp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [151:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid, out_tready;
  logic [143:0] out_tdata;
  logic         out_tuser;
  int           fail_count, pending;
  int           send_idle, recv_idle;
  int           cycles;
  int           next_joint;

  skeleton_joint_matrix_palette u_dut (.*);

  skeleton_joint_matrix_palette_chk u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("skeleton_joint_matrix_palette verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk)
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle);

  function automatic logic [31:0] rand_val(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(131072)) - 65536);
      2: return 32'h0001_0000;
      default: return $urandom_range(3) == 0 ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  // tvalid stays high between back-to-back beats; it drops only while idling
  task automatic send_beat(logic [1:0] kind, logic [7:0] j, logic [7:0] p, logic [1:0] c,
                           logic [31:0] a, logic [31:0] b, logic [31:0] d, logic [31:0] e);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= kind;
    in_tdata  <= {e, d, b, a, c, p, j};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // one joint: translation, rotation, scale, four bind columns; mode picks value style
  task automatic send_joint(logic [7:0] j, int mode);
    logic [7:0] p;
    p = (j == 0) ? 8'($urandom()) : 8'($urandom_range(j - 1));
    if ($urandom_range(9) == 0) p = 8'($urandom());
    send_beat(REQ_TRANS, j, p, 2'($urandom()), rand_val(mode), rand_val(mode),
              rand_val(mode), rand_val(0));
    send_beat(REQ_ROT, j, 8'($urandom()), 2'($urandom()), rand_val(mode), rand_val(mode),
              rand_val(mode), rand_val(mode));
    send_beat(REQ_SCALE, j, 8'($urandom()), 2'($urandom()), rand_val(mode), rand_val(mode),
              rand_val(mode), rand_val(0));
    for (int c = 0; c < 4; c++)
      send_beat(REQ_COL, j, 8'($urandom()), 2'(c), rand_val(mode), rand_val(mode),
                rand_val(mode), rand_val(mode));
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    send_idle = 0; recv_idle = 0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: columns off identity store, scale with held zeros, extremes
    send_beat(REQ_COL, 8'd5, 8'd0, 2'd3, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
              32'hffff_ffff);
    send_beat(REQ_SCALE, 8'd0, 8'd0, 2'd0, 32'h0001_0000, 32'h0002_0000, 32'h8000_0000, 0);
    send_beat(REQ_COL, 8'd0, 8'd0, 2'd0, 32'h0001_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_joint(8'd0, 3);
    send_joint(8'd1, 2);
    // parent not yet computed
    send_beat(REQ_TRANS, 8'd2, 8'd200, 2'd0, 32'h0003_0000, 0, 32'hfffd_0000, 0);
    send_beat(REQ_ROT, 8'd2, 8'd0, 2'd0, 0, 0, 32'h0000_b505, 32'h0000_b505);
    send_beat(REQ_SCALE, 8'd2, 8'd255, 2'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
    send_beat(REQ_COL, 8'd2, 8'd255, 2'd1, 32'hffff_ffff, 32'h0001_0000, 0, 32'h8000_0000);
    send_beat(REQ_COL, 8'd255, 8'd255, 2'd2, 32'h0001_0000, 0, 0, 32'h0001_0000);
    wait_drained();

    next_joint = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 38 : (ph == 1) ? 62 : 0;
      recv_idle = (ph == 0) ? 62 : (ph == 1) ? 38 : 0;
      for (int n = 0; n < 28; n++) begin
        if ($urandom_range(7) == 0) begin
          // noise beat
          send_beat(2'($urandom()), 8'($urandom()), 8'($urandom()), 2'($urandom()),
                    rand_val($urandom_range(3)), rand_val(0), rand_val(1), rand_val(0));
        end else begin
          send_joint(8'(next_joint), $urandom_range(4) < 3 ? 1 : $urandom_range(3));
          next_joint = (next_joint + 1 + $urandom_range(3)) % 256;
        end
        if (n == 10) wait_drained();
      end
    end

    send_idle = 0;
    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("skeleton_joint_matrix_palette verification clean");
    else
      $display("skeleton_joint_matrix_palette verification failed");
    $finish;
  end
endmodule
